FILE: rtl/mlcp_pkg.sv
// ----------------------------------------------------------------------------
// mlcp_pkg
// Shared constants, label tables and helpers for the meter line parser.
// ----------------------------------------------------------------------------
package mlcp_pkg;

   localparam int CODE_W     = 5;
   localparam int NUM_LABELS = 22;

   typedef logic [CODE_W-1:0] label_code_type;

   localparam label_code_type UNKNOWN_LABEL = label_code_type'(NUM_LABELS);

   // Special bytes of the serial stream
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Checksum is the six-bit byte sum plus this offset
   localparam logic [7:0] CHECK_OFFSET = 8'h20;

   localparam logic [39:0] VALUE_MAX = 40'd999999999999;

   // Label text, right aligned, first character in the highest used byte
   localparam logic [63:0] LABEL_TEXT [NUM_LABELS] = '{
      64'("ADCO"),    64'("OPTARIF"), 64'("ISOUSC"),  64'("BASE"),
      64'("HCHC"),    64'("HCHP"),    64'("EJPHPM"),  64'("EJPHN"),
      64'("BBRHCJB"), 64'("BBRHPJB"), 64'("BBRHCJW"), 64'("BBRHPJW"),
      64'("BBRHCJR"), 64'("BBRHPJR"), 64'("PTEC"),    64'("IINST"),
      64'("IMAX"),    64'("PAPP"),    64'("DEMAIN"),  64'("HHPHC"),
      64'("ADPS"),    64'("MOTDETAT")
   };

   localparam logic [3:0] LABEL_LEN [NUM_LABELS] = '{
      4'd4, 4'd7, 4'd6, 4'd4, 4'd4, 4'd4, 4'd6, 4'd5,
      4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd4, 4'd5,
      4'd4, 4'd4, 4'd6, 4'd5, 4'd4, 4'd8
   };

   // Width of each label's value field in characters
   localparam logic [3:0] LABEL_FIELD_W [NUM_LABELS] = '{
      4'd12, 4'd4, 4'd2, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9,
      4'd9,  4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd4, 4'd3,
      4'd3,  4'd5, 4'd4, 4'd1, 4'd3, 4'd6
   };

   // Field width for a label code; zero for the unknown code
   function automatic logic [3:0] field_width(input label_code_type code);
      logic [3:0] fw;
      fw = '0;
      for (int k = 0; k < NUM_LABELS; k++) begin
         if (code == label_code_type'(k)) begin
            fw = LABEL_FIELD_W[k];
         end
      end
      return fw;
   endfunction

endpackage

FILE: rtl/mlcp_label_lookup.sv
// ----------------------------------------------------------------------------
// mlcp_label_lookup
// Matches the gathered label characters and length against the label table.
// ----------------------------------------------------------------------------
module mlcp_label_lookup #(
   parameter int LEN_W = 6
) (
   input  logic [63:0]             label_chars,
   input  logic [LEN_W-1:0]        label_len,
   output mlcp_pkg::label_code_type code
);
   import mlcp_pkg::*;

   always_comb begin
      logic [63:0] mask;
      code = UNKNOWN_LABEL;
      for (int k = 0; k < NUM_LABELS; k++) begin
         mask = (LABEL_LEN[k] == 4'd8) ? {64{1'b1}}
                                       : ((64'd1 << (8 * LABEL_LEN[k])) - 64'd1);
         if (label_len == LEN_W'(LABEL_LEN[k]) &&
             (label_chars & mask) == LABEL_TEXT[k]) begin
            code = label_code_type'(k);
         end
      end
   end

endmodule

FILE: rtl/meter_line_checksum_parser_core.sv
// ----------------------------------------------------------------------------
// meter_line_checksum_parser_core
// Gathers meter serial bytes into lines, checks each line's checksum, looks
// up its label and decodes the label's decimal value field.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_stall  | rx_byte, chunk_end
//   rsp_     | out       | rsp_valid/rsp_stall  | checksum_ok, label_code,
//            |           |                      | value_number, value_is_number,
//            |           |                      | value_head, truncated
//
// One byte per cycle while the result is not stalled; the byte that closes a
// line passes the input register, then the result register, raising rsp_valid.
// Line state lives in registers updated by one pass of logic per byte.
// Synchronous reset clears the line state and both stage valids.
// A stalled result holds and backs up into req_stall only once the input
// register also holds a byte.
// ----------------------------------------------------------------------------
module meter_line_checksum_parser_core #(
   parameter int LINE_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_chunk_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_checksum_ok,
   output logic [4:0]  rsp_label_code,
   output logic [39:0] rsp_value_number,
   output logic        rsp_value_is_number,
   output logic [31:0] rsp_value_head,
   output logic        rsp_truncated
);
   import mlcp_pkg::*;

   localparam int LEN_W = $clog2(LINE_BYTES);
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BYTES - 1);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_chunk_ff;

   // Line state
   logic [LEN_W-1:0] len_ff, len_in;
   logic [5:0]       sum_ff, sum_in;
   logic [15:0]      last_ff, last_in;
   logic [63:0]      chars_ff, chars_in;
   logic             space_ff, space_in;
   label_code_type   match_ff, match_in;
   logic [3:0]       digits_ff, digits_in;
   logic [39:0]      acc_ff, acc_in;
   logic             all_ff, all_in;
   logic [31:0]      head_ff, head_in;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic        out_ok_ff;
   logic [4:0]  out_code_ff;
   logic [39:0] out_num_ff;
   logic        out_isnum_ff;
   logic [31:0] out_head_ff;
   logic        out_trunc_ff;

   logic out_block, advance;
   logic is_clear_byte, is_cr, close, emit, store, clear;
   label_code_type lookup_code;

   logic [7:0]  sum_wide;
   logic [3:0]  digit;
   logic [43:0] acc_next;
   logic        ok, known, is_num;

   assign out_block = out_valid_ff && rsp_stall;
   assign advance   = in_valid_ff && !out_block;
   assign req_stall = in_valid_ff && out_block;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (!req_stall) begin
         in_byte_ff  <= req_rx_byte;
         in_chunk_ff <= req_chunk_end;
      end
   end

   mlcp_label_lookup #(
      .LEN_W(LEN_W)
   ) u_label_lookup (
      .label_chars(chars_ff),
      .label_len  (len_ff),
      .code       (lookup_code)
   );

   always_comb begin
      is_clear_byte = (in_byte_ff == CHAR_LF) || (in_byte_ff == CHAR_NUL);
      is_cr         = (in_byte_ff == CHAR_CR);
      close         = !is_clear_byte && (is_cr || len_ff >= LEN_LAST);
      emit          = close && (len_ff != '0);
      store         = !is_clear_byte && !close;
      clear         = is_clear_byte || close || in_chunk_ff;

      sum_wide = {2'b00, sum_ff} + last_ff[15:8];
      digit    = 4'(in_byte_ff - CHAR_ZERO);
      acc_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {40'd0, digit};

      ok     = (({2'b00, sum_ff} + CHECK_OFFSET) == last_ff[7:0]);
      known  = ok && (match_ff != UNKNOWN_LABEL);
      is_num = known && all_ff && (digits_ff != 4'd0);
   end

   // Line state next value
   always_comb begin
      len_in    = len_ff;
      sum_in    = sum_ff;
      last_in   = last_ff;
      chars_in  = chars_ff;
      space_in  = space_ff;
      match_in  = match_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      all_in    = all_ff;
      head_in   = head_ff;
      if (advance) begin
         if (clear) begin
            len_in    = '0;
            sum_in    = '0;
            last_in   = '0;
            chars_in  = '0;
            space_in  = 1'b0;
            match_in  = UNKNOWN_LABEL;
            digits_in = '0;
            acc_in    = '0;
            all_in    = 1'b1;
            head_in   = '0;
         end else if (store) begin
            len_in  = len_ff + LEN_W'(1);
            last_in = {last_ff[7:0], in_byte_ff};
            if (len_ff >= LEN_W'(2)) begin
               sum_in = sum_wide[5:0];
            end
            if (!space_ff) begin
               if (in_byte_ff == CHAR_SPACE) begin
                  space_in = 1'b1;
                  match_in = lookup_code;
               end else begin
                  chars_in = {chars_ff[55:0], in_byte_ff};
               end
            end else if (match_ff != UNKNOWN_LABEL &&
                         digits_ff < field_width(match_ff)) begin
               if (digits_ff[3:2] == 2'b00) begin
                  case (digits_ff[1:0])
                     2'd0:    head_in[31:24] = head_ff[31:24] | in_byte_ff;
                     2'd1:    head_in[23:16] = head_ff[23:16] | in_byte_ff;
                     2'd2:    head_in[15:8]  = head_ff[15:8]  | in_byte_ff;
                     default: head_in[7:0]   = head_ff[7:0]   | in_byte_ff;
                  endcase
               end
               if (in_byte_ff >= CHAR_ZERO && in_byte_ff <= CHAR_NINE) begin
                  // saturate at the largest twelve-digit value
                  acc_in = (acc_next > {4'd0, VALUE_MAX}) ? VALUE_MAX : acc_next[39:0];
               end else begin
                  all_in = 1'b0;
               end
               digits_in = digits_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         sum_ff    <= '0;
         last_ff   <= '0;
         chars_ff  <= '0;
         space_ff  <= 1'b0;
         match_ff  <= UNKNOWN_LABEL;
         digits_ff <= '0;
         acc_ff    <= '0;
         all_ff    <= 1'b1;
         head_ff   <= '0;
      end else begin
         len_ff    <= len_in;
         sum_ff    <= sum_in;
         last_ff   <= last_in;
         chars_ff  <= chars_in;
         space_ff  <= space_in;
         match_ff  <= match_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
         all_ff    <= all_in;
         head_ff   <= head_in;
      end
   end

   // Hold a stalled result; otherwise load on a closing byte
   assign out_valid_in = out_block ? 1'b1 : (advance && emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && emit) begin
         out_ok_ff    <= ok;
         out_code_ff  <= known ? match_ff : UNKNOWN_LABEL;
         out_num_ff   <= is_num ? acc_ff : '0;
         out_isnum_ff <= is_num;
         out_head_ff  <= known ? head_ff : '0;
         out_trunc_ff <= !is_cr;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_checksum_ok     = out_ok_ff;
   assign rsp_label_code      = out_code_ff;
   assign rsp_value_number    = out_num_ff;
   assign rsp_value_is_number = out_isnum_ff;
   assign rsp_value_head      = out_head_ff;
   assign rsp_truncated       = out_trunc_ff;

endmodule

FILE: rtl/mlcp_checker.sv
// ----------------------------------------------------------------------------
// mlcp_checker
// Port-level checks on the meter line parser, bound to the top level.
// ----------------------------------------------------------------------------
module mlcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_checksum_ok,
   input logic [4:0]  rsp_label_code,
   input logic [39:0] rsp_value_number,
   input logic        rsp_value_is_number,
   input logic [31:0] rsp_value_head,
   input logic        rsp_truncated
);
   import mlcp_pkg::*;

   // No result and no input stall right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("result valid or input stalled after reset");

   // A known label only comes with a good checksum
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_label_code != UNKNOWN_LABEL |-> rsp_checksum_ok)
      else $error("label reported on bad checksum");

   // A number needs a known label
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_is_number |-> rsp_label_code != UNKNOWN_LABEL)
      else $error("number without known label");

   // Non-numbers read as zero; numbers stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value_is_number || rsp_value_number == '0) &&
                    rsp_value_number <= VALUE_MAX)
      else $error("value field out of range");

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_number) &&
                                 $stable(rsp_label_code) &&
                                 $stable(rsp_checksum_ok) &&
                                 $stable(rsp_value_is_number) &&
                                 $stable(rsp_value_head) &&
                                 $stable(rsp_truncated))
      else $error("stalled result changed");

endmodule

bind meter_line_checksum_parser_core mlcp_checker u_mlcp_checker (.*);

FILE: tb/meter_line_checksum_parser_core_tb.sv
// ----------------------------------------------------------------------------
// meter_line_checksum_parser_core_tb
// Self-checking bench for the meter line parser. Sends hand-picked lines and
// then random meter lines, bad checksums, unknown labels, overlong lines and
// noise through the byte channel. A line predictor keeps its own line state
// and queues the expected result of every closed line. Each result transfer
// is compared field by field, under several sender-idle and receiver-stall
// mixes.
// ----------------------------------------------------------------------------
package meter_line_tb_pkg;
   import mlcp_pkg::*;

   localparam int LINE_BYTES = 64;

   typedef logic [7:0] line_bytes_type[$];

   typedef struct packed {
      logic           checksum_ok;
      label_code_type label_code;
      logic [39:0]    value_number;
      logic           value_is_number;
      logic [31:0]    value_head;
      logic           truncated;
   } line_result_type;

   function automatic line_bytes_type text_bytes(string s);
      line_bytes_type q;
      for (int i = 0; i < s.len(); i++) begin
         q = {q, s[i]};
      end
      return q;
   endfunction

   function automatic logic end_of_chunk(int odds);
      return odds > 0 && $urandom_range(odds - 1) == 0;
   endfunction

   class line_scoreboard;
      string           label_name[NUM_LABELS];
      int unsigned     field_w[NUM_LABELS];
      line_result_type closed_lines[$];
      int              failures;
      int unsigned     line_len;
      logic [5:0]      byte_sum;
      logic [15:0]     last_two;
      logic [63:0]     label_chars;
      logic            space_seen;
      label_code_type  label_hit;
      int unsigned     digits;
      longint unsigned value_acc;
      logic            all_digits;
      logic [31:0]     head;

      function new();
         label_name = '{"ADCO", "OPTARIF", "ISOUSC", "BASE", "HCHC", "HCHP",
                        "EJPHPM", "EJPHN", "BBRHCJB", "BBRHPJB", "BBRHCJW",
                        "BBRHPJW", "BBRHCJR", "BBRHPJR", "PTEC", "IINST",
                        "IMAX", "PAPP", "DEMAIN", "HHPHC", "ADPS", "MOTDETAT"};
         field_w = '{12, 4, 2, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 4, 3, 3, 5, 4,
                     1, 3, 6};
         failures = 0;
         clear_line();
      endfunction

      function void clear_line();
         line_len = 0;
         byte_sum = '0;
         last_two = '0;
         label_chars = '0;
         space_seen = 1'b0;
         label_hit = UNKNOWN_LABEL;
         digits = 0;
         value_acc = 0;
         all_digits = 1'b1;
         head = '0;
      endfunction

      // Label text sits in the low bytes of label_chars, first char highest
      function label_code_type lookup_label();
         logic [63:0] mask;
         logic [63:0] text_bits;
         string s;
         if (line_len == 0 || line_len > 8) return UNKNOWN_LABEL;
         mask = (line_len == 8) ? '1 : (64'd1 << (8 * line_len)) - 64'd1;
         for (int k = 0; k < NUM_LABELS; k++) begin
            s = label_name[k];
            if (s.len() == line_len) begin
               text_bits = '0;
               for (int i = 0; i < s.len(); i++) begin
                  text_bits = {text_bits[55:0], s[i]};
               end
               if (text_bits == (label_chars & mask)) return label_code_type'(k);
            end
         end
         return UNKNOWN_LABEL;
      endfunction

      function void store_byte(logic [7:0] c);
         // the sum trails two bytes behind the newest one
         if (line_len >= 2) byte_sum = byte_sum + last_two[13:8];
         last_two = {last_two[7:0], c};
         if (!space_seen) begin
            if (c == CHAR_SPACE) begin
               space_seen = 1'b1;
               label_hit = lookup_label();
            end else begin
               label_chars = {label_chars[55:0], c};
            end
         end else if (label_hit < NUM_LABELS && digits < field_w[label_hit]) begin
            if (digits < 4) head = head | (32'(c) << (8 * (3 - digits)));
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               value_acc = value_acc * 10 + (c - CHAR_ZERO);
               if (value_acc > VALUE_MAX) value_acc = VALUE_MAX;
            end else begin
               all_digits = 1'b0;
            end
            digits++;
         end
         line_len++;
      endfunction

      function void note_byte(logic [7:0] c, logic ce);
         line_result_type r;
         logic ok;
         logic known;
         logic is_num;
         if (c == CHAR_LF || c == CHAR_NUL) begin
            clear_line();
         end else if (c == CHAR_CR || line_len >= LINE_BYTES - 1) begin
            if (line_len > 0) begin
               ok = ({2'b00, byte_sum} + CHECK_OFFSET) == last_two[7:0];
               known = ok && (label_hit < NUM_LABELS);
               is_num = known && all_digits && digits > 0;
               r.checksum_ok = ok;
               r.label_code = known ? label_hit : UNKNOWN_LABEL;
               r.value_number = is_num ? value_acc[39:0] : '0;
               r.value_is_number = is_num;
               r.value_head = known ? head : '0;
               // drop the byte that would fill the store
               r.truncated = (c != CHAR_CR);
               closed_lines = {closed_lines, r};
            end
            clear_line();
         end else begin
            store_byte(c);
         end
         if (ce) clear_line();
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(line_result_type got);
         line_result_type want;
         if (closed_lines.size() == 0) begin
            $error("result transfer with no line waiting, label_code %0d",
                   got.label_code);
            failures++;
            return;
         end
         want = closed_lines.pop_front();
         compare_field("checksum_ok", want.checksum_ok, got.checksum_ok);
         compare_field("label_code", want.label_code, got.label_code);
         compare_field("value_number", want.value_number, got.value_number);
         compare_field("value_is_number", want.value_is_number, got.value_is_number);
         compare_field("value_head", want.value_head, got.value_head);
         compare_field("truncated", want.truncated, got.truncated);
      endfunction
   endclass

endpackage

module meter_line_checksum_parser_core_tb;
   import mlcp_pkg::*;
   import meter_line_tb_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RANDOM_BYTES  = 400;
   localparam int DRAIN_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_LIMIT     = 2000000;
   localparam int SEND_IDLE[4]  = '{0, 77, 0, 21};
   localparam int RSP_STALL[4]  = '{0, 0, 77, 21};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = '0;
   logic        req_chunk_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_checksum_ok;
   logic [4:0]  rsp_label_code;
   logic [39:0] rsp_value_number;
   logic        rsp_value_is_number;
   logic [31:0] rsp_value_head;
   logic        rsp_truncated;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int bytes_sent = 0;

   line_scoreboard meter_sb = new();

   meter_line_checksum_parser_core #(
      .LINE_BYTES(LINE_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .req_chunk_end(req_chunk_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_checksum_ok(rsp_checksum_ok),
      .rsp_label_code(rsp_label_code),
      .rsp_value_number(rsp_value_number),
      .rsp_value_is_number(rsp_value_is_number),
      .rsp_value_head(rsp_value_head),
      .rsp_truncated(rsp_truncated)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct > 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      line_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.checksum_ok = rsp_checksum_ok;
         got.label_code = rsp_label_code;
         got.value_number = rsp_value_number;
         got.value_is_number = rsp_value_is_number;
         got.value_head = rsp_value_head;
         got.truncated = rsp_truncated;
         meter_sb.check_result(got);
      end
   end

   // Hold the byte until its transfer, then maybe go idle for a while
   task automatic send_byte(input logic [7:0] b, input logic ce);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_chunk_end <= ce;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      meter_sb.note_byte(b, ce);
      bytes_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'($urandom);
         req_chunk_end <= 1'($urandom);
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Body ends with the byte before the checksum; the checksum covers
   // everything but that byte
   task automatic send_line(input line_bytes_type body, input bit good,
                            input logic [7:0] term, input int ce_odds);
      logic [5:0] sum;
      logic [7:0] ck;
      sum = '0;
      for (int i = 0; i + 1 < body.size(); i++) begin
         sum = sum + body[i][5:0];
      end
      ck = {2'b00, sum} + CHECK_OFFSET;
      if (!good) ck = ck + 8'd1;
      foreach (body[i]) begin
         send_byte(body[i], end_of_chunk(ce_odds));
      end
      send_byte(ck, end_of_chunk(ce_odds));
      send_byte(term, end_of_chunk(ce_odds));
   endtask

   initial begin
      #(RUN_LIMIT);
      $display("meter_line_checksum_parser_core_tb: errors");
      $finish;
   end

   initial begin
      line_bytes_type body;
      int          pick;
      int          k;
      int          w;
      int          n;
      int          v;
      int          pos;
      int          directed_end;
      int          guard;
      bit          good;
      logic [7:0]  term;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_byte(CHAR_NUL, 1'b0);
      send_byte(CHAR_LF, 1'b0);
      send_byte(CHAR_CR, 1'b0);
      // one-byte line: checksum is the bare offset
      send_byte(CHAR_SPACE, 1'b0);
      send_byte(CHAR_CR, 1'b0);
      send_byte("A", 1'b0);
      send_byte(CHAR_CR, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_line(text_bytes("HHPHC 7 "), 1'b1, CHAR_CR, 0);
      // value field runs short and swallows the space
      send_line(text_bytes("ISOUSC 3 "), 1'b1, CHAR_CR, 0);
      directed_end = bytes_sent;

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = SEND_IDLE[ph];
         rsp_stall_pct = RSP_STALL[ph];
         while (bytes_sent < directed_end + RANDOM_BYTES * (ph + 1) / 4) begin
            pick = $urandom_range(99);
            body.delete();
            good = 1'b1;
            term = CHAR_CR;
            if (pick >= 88) begin
               n = $urandom_range(1, 6);
               repeat (n) send_byte(8'($urandom_range(255)), end_of_chunk(8));
               if ($urandom_range(1)) send_byte(CHAR_CR, 1'b0);
            end else begin
               if (pick < 65 || pick >= 80) begin
                  k = $urandom_range(NUM_LABELS - 1);
                  body = text_bytes(meter_sb.label_name[k]);
                  body = {body, CHAR_SPACE};
                  w = meter_sb.field_w[k];
                  v = $urandom_range(9);
                  n = (v == 0) ? $urandom_range(w - 1) : w;
                  pos = (v == 1) ? $urandom_range(n - 1) : -1;
                  for (int i = 0; i < n; i++) begin
                     if (i == pos) body = {body, 8'($urandom_range(8'h21, 8'hFF))};
                     else if (v == 2) body = {body, CHAR_NINE};
                     else body = {body, 8'(CHAR_ZERO + 8'($urandom_range(9)))};
                  end
                  good = (pick < 55) || (pick >= 80 && $urandom_range(1) == 1);
                  if (pick >= 80) begin
                     // pad so the checksum byte lands in the last slot
                     while (body.size() < LINE_BYTES - 3) begin
                        body = {body, 8'($urandom_range(8'h21, 8'hFF))};
                     end
                     if ($urandom_range(1)) term = 8'($urandom_range(8'h21, 8'hFF));
                  end
                  body = {body, CHAR_SPACE};
               end else if (pick < 75) begin
                  n = $urandom_range(11);
                  repeat (n) body = {body, 8'(8'h41 + 8'($urandom_range(25)))};
                  body = {body, CHAR_SPACE};
                  n = $urandom_range(3);
                  repeat (n) body = {body, 8'(CHAR_ZERO + 8'($urandom_range(9)))};
                  body = {body, CHAR_SPACE};
               end else begin
                  n = $urandom_range(1, 12);
                  repeat (n) body = {body, 8'(8'h41 + 8'($urandom_range(25)))};
               end
               send_line(body, good, term, ($urandom_range(3) == 0) ? 32 : 0);
            end
         end
      end

      req_valid <= 1'b0;
      rsp_stall_pct = 0;
      guard = 0;
      while (meter_sb.closed_lines.size() > 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (meter_sb.closed_lines.size() > 0) begin
         $error("%0d closed lines never produced a result",
                meter_sb.closed_lines.size());
         meter_sb.failures++;
      end
      if (meter_sb.failures == 0) begin
         $display("meter_line_checksum_parser_core_tb: clean");
      end else begin
         $display("meter_line_checksum_parser_core_tb: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/mlcp_pkg.sv
rtl/mlcp_label_lookup.sv
rtl/meter_line_checksum_parser_core.sv
rtl/mlcp_checker.sv
tb/meter_line_checksum_parser_core_tb.sv
